### hdl/att_pkg.sv
// Shared types and constants for the alarm timer table.
package att_pkg;

   localparam int NUM_ALARMS = 8;
   localparam int SLOT_BITS = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
   localparam int CNT_BITS = $clog2(NUM_ALARMS + 1);
   localparam int EVENT_BITS = 8;
   localparam int DELAY_BITS = 31;
   localparam int AUX_BITS = 32;
   localparam int ELAPSED_BITS = 32;
   localparam int PERIOD_BITS = 16;

   localparam logic KIND_PROGRAM = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [0:0] ADDR_TICK_PERIOD = 1'b0;
   localparam logic [PERIOD_BITS-1:0] TICK_PERIOD_RESET = 16'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;       // capture request, clear scan index
      logic step;       // process slot at scan index, advance
      logic commit;     // write program item into chosen slot
      logic cancel;     // cancel pass at scan index
      logic show_fire;  // present lowest pending fired slot on output
      logic show_ovf;   // present overflow result
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic is_cancel;
      logic scan_done;  // index at last slot
      logic fired;      // some fired slot still waits to be emitted
      logic have_pick;
      logic out_busy;
   } status_type;

endpackage

### hdl/alarm_timer_table.sv
// Top level of the alarm timer table.
// Input transfers (req_) carry one item, its kind in tuser: kind 0 programs or
// cancels an alarm, kind 1 is a timer tick. A tick advances every active slot
// by tick_period_ms and returns one result transfer per fired slot, in slot
// order, tlast on the final one; a program item returns only an overflow
// result (tuser high) when no slot is free, and a cancel returns nothing.
// The CSR port holds tick_period_ms at byte address 0.
// An item is taken in the idle state and scanned one slot per cycle; a tick
// then emits its fired slots, and a program item writes its chosen slot or
// returns an overflow result.
// A result waits in the output register while rsp_tready is low; emission
// and overflow hold until it leaves. The last result of an item may still
// wait there while the next item is taken.
// Reset clears every slot to event 0, inactive, and sets tick_period_ms to 1.
module alarm_timer_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // event_id, delay_ms, periodic, aux_data
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // out_event_id, out_aux_data
   output logic        rsp_tuser,  // overflow
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [att_pkg::PERIOD_BITS-1:0] period_ff;
   att_pkg::cmd_type    cmd;
   att_pkg::status_type status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2:2] == att_pkg::ADDR_TICK_PERIOD) ? {16'd0, period_ff}
                                                                     : '0;

   always_ff @(posedge clock) begin
      if (reset) period_ff <= att_pkg::TICK_PERIOD_RESET;
      else if (csr_psel && csr_penable && csr_pwrite
               && csr_paddr[2:2] == att_pkg::ADDR_TICK_PERIOD)
         period_ff <= csr_pwdata[15:0];
   end

   att_control u_ctl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .status(status), .cmd(cmd)
   );

   att_datapath u_dp (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .tick_period(period_ff), .cmd(cmd), .status(status),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );
endmodule

### hdl/att_datapath.sv
// Slot table, scan index and result register of the alarm timer table.
module att_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic [71:0]                     req_tdata,
   input  logic                            req_tuser,
   input  logic [att_pkg::PERIOD_BITS-1:0] tick_period,
   input  att_pkg::cmd_type                cmd,
   output att_pkg::status_type             status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   localparam int NA = att_pkg::NUM_ALARMS;

   logic [att_pkg::EVENT_BITS-1:0]   ev_ff   [NA];
   logic [att_pkg::AUX_BITS-1:0]     aux_ff  [NA];
   logic [att_pkg::ELAPSED_BITS-1:0] el_ff   [NA];
   logic [att_pkg::DELAY_BITS-1:0]   dly_ff  [NA];
   logic [NA-1:0]                    per_ff;
   logic [NA-1:0]                    act_ff;

   logic                             kind_ff;
   logic [att_pkg::EVENT_BITS-1:0]   r_ev_ff;
   logic [att_pkg::DELAY_BITS-1:0]   r_dly_ff;
   logic                             r_per_ff;
   logic [att_pkg::AUX_BITS-1:0]     r_aux_ff;
   logic [att_pkg::SLOT_BITS-1:0]    idx_ff;
   logic                             free_ok_ff, matched_ff;
   logic [att_pkg::SLOT_BITS-1:0]    pick_ff, free_ff;
   logic [NA-1:0]                    pend_ff;

   logic                             ovld_ff;
   logic [att_pkg::EVENT_BITS-1:0]   o_ev_ff;
   logic [att_pkg::AUX_BITS-1:0]     o_aux_ff;
   logic                             o_ovf_ff, o_last_ff;

   logic [att_pkg::ELAPSED_BITS:0]   sum;
   logic [att_pkg::ELAPSED_BITS-1:0] sat;
   logic                             fire_now;
   logic                             hit;
   logic [att_pkg::SLOT_BITS-1:0]    emit_idx;
   logic [NA-1:0]                    pend_rest;

   assign sum = {1'b0, el_ff[idx_ff]} + {17'd0, tick_period};
   assign sat = sum[att_pkg::ELAPSED_BITS] ? '1 : sum[att_pkg::ELAPSED_BITS-1:0];
   assign fire_now = act_ff[idx_ff] && (sat >= {1'b0, dly_ff[idx_ff]});
   assign hit = (ev_ff[idx_ff] == r_ev_ff) && (aux_ff[idx_ff] == r_aux_ff);

   always_comb begin
      emit_idx = '0;
      for (int i = NA - 1; i >= 0; i--) begin
         if (pend_ff[i]) emit_idx = att_pkg::SLOT_BITS'(i);
      end
      pend_rest = pend_ff;
      pend_rest[emit_idx] = 1'b0;
   end

   assign status.is_tick    = (kind_ff == att_pkg::KIND_TICK);
   assign status.is_cancel  = (r_dly_ff == '0) && !r_per_ff;
   assign status.scan_done  = (idx_ff == att_pkg::SLOT_BITS'(NA - 1));
   assign status.fired      = |pend_ff;
   assign status.have_pick  = matched_ff || free_ok_ff;
   assign status.out_busy   = ovld_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
         per_ff <= '0;
         for (int i = 0; i < NA; i++) begin
            ev_ff[i] <= '0;
            aux_ff[i] <= '0;
            el_ff[i] <= '0;
            dly_ff[i] <= '0;
         end
         ovld_ff <= 1'b0;
         idx_ff <= '0;
         pend_ff <= '0;
      end else begin
         if (cmd.load && req_tvalid) begin
            kind_ff <= req_tuser;
            r_ev_ff <= req_tdata[7:0];
            r_dly_ff <= req_tdata[38:8];
            r_per_ff <= req_tdata[39];
            r_aux_ff <= req_tdata[71:40];
            idx_ff <= '0;
            matched_ff <= 1'b0;
            free_ok_ff <= 1'b0;
            pend_ff <= '0;
         end
         if (cmd.cancel) begin
            if (ev_ff[idx_ff] == r_ev_ff) begin
               act_ff[idx_ff] <= 1'b0;
            end
            idx_ff <= idx_ff + att_pkg::SLOT_BITS'(1);
         end
         if (cmd.step) begin
            if (kind_ff == att_pkg::KIND_TICK) begin
               if (act_ff[idx_ff]) begin
                  if (fire_now) begin
                     pend_ff[idx_ff] <= 1'b1;
                     if (per_ff[idx_ff]) begin
                        el_ff[idx_ff] <= '0;
                     end else begin
                        el_ff[idx_ff] <= sat;
                        act_ff[idx_ff] <= 1'b0;
                     end
                  end else begin
                     el_ff[idx_ff] <= sat;
                  end
               end
            end else if (!matched_ff) begin
               if (hit) begin
                  matched_ff <= 1'b1;
                  pick_ff <= idx_ff;
               end else if (!act_ff[idx_ff] && !free_ok_ff) begin
                  free_ok_ff <= 1'b1;
                  free_ff <= idx_ff;
               end
            end
            if (!status.scan_done) begin
               idx_ff <= idx_ff + att_pkg::SLOT_BITS'(1);
            end
         end
         if (cmd.commit) begin
            if (matched_ff) begin
               ev_ff[pick_ff] <= r_ev_ff;
               aux_ff[pick_ff] <= r_aux_ff;
               el_ff[pick_ff] <= '0;
               dly_ff[pick_ff] <= r_dly_ff;
               per_ff[pick_ff] <= r_per_ff;
               act_ff[pick_ff] <= 1'b1;
            end else begin
               ev_ff[free_ff] <= r_ev_ff;
               aux_ff[free_ff] <= r_aux_ff;
               el_ff[free_ff] <= '0;
               dly_ff[free_ff] <= r_dly_ff;
               per_ff[free_ff] <= r_per_ff;
               act_ff[free_ff] <= 1'b1;
            end
         end
         if (cmd.show_fire) begin
            ovld_ff <= 1'b1;
            o_ev_ff <= ev_ff[emit_idx];
            o_aux_ff <= aux_ff[emit_idx];
            o_ovf_ff <= 1'b0;
            o_last_ff <= (pend_rest == '0);
            pend_ff[emit_idx] <= 1'b0;
         end else if (cmd.show_ovf) begin
            ovld_ff <= 1'b1;
            o_ev_ff <= '0;
            o_aux_ff <= '0;
            o_ovf_ff <= 1'b1;
            o_last_ff <= 1'b1;
         end else if (rsp_tready) begin
            ovld_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata = {o_aux_ff, o_ev_ff};
   assign rsp_tuser = o_ovf_ff;
   assign rsp_tlast = o_last_ff;
endmodule

### hdl/att_control.sv
// Sequencer that steps the slot scan, emission and table update.
module att_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  att_pkg::status_type status,
   output att_pkg::cmd_type    cmd
);
   att_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         att_pkg::ST_IDLE:
            if (req_tvalid) state_in = att_pkg::ST_SCAN;
         att_pkg::ST_SCAN:
            if (status.scan_done) begin
               if (status.is_tick) state_in = att_pkg::ST_EMIT;
               else if (status.is_cancel) state_in = att_pkg::ST_IDLE;
               else state_in = att_pkg::ST_WRITE;
            end
         att_pkg::ST_EMIT:
            if (!status.fired) state_in = att_pkg::ST_IDLE;
         att_pkg::ST_WRITE:
            if (status.have_pick || !status.out_busy) state_in = att_pkg::ST_IDLE;
         default: state_in = att_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         att_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load = 1'b1;
         end
         att_pkg::ST_SCAN:
            if (!status.is_tick && status.is_cancel) cmd.cancel = 1'b1;
            else cmd.step = 1'b1;
         att_pkg::ST_EMIT:
            if (status.fired && !status.out_busy) cmd.show_fire = 1'b1;
         att_pkg::ST_WRITE:
            if (status.have_pick) cmd.commit = 1'b1;
            else if (!status.out_busy) cmd.show_ovf = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= att_pkg::ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
